@@ rtl/core/rpwa_pkg.sv @@
// Shared constants for the RC pulse-width averager.
// No dependencies; used by rc_pulse_width_averager_top.
`default_nettype none

package rpwa_pkg;

    // Field widths of the edge-event and result words
    localparam int unsigned CHANNEL_W = 2;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned SAMPLE_W  = 16;

    // Running sum holds up to 16 samples of 65535 without loss
    localparam int unsigned SUM_W     = 20;

    // Pin level codes
    localparam logic LEVEL_LOW  = 1'b0;
    localparam logic LEVEL_HIGH = 1'b1;

    // Largest pulse width; longer pulses saturate here
    localparam logic [SAMPLE_W-1:0] WIDTH_MAX = {SAMPLE_W{1'b1}};

endpackage

`default_nettype wire

@@ rtl/core/rpwa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module rpwa_ram #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned DEPTH  = 40,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rc_pulse_width_averager_top.sv @@
// RC receiver PWM decoder: per-channel pulse width with a moving average.
// Depends on rpwa_pkg and rpwa_ram.
`default_nettype none

// Takes one pin-change word per cycle. A rising edge stores the channel's
// start time and gives no result; a falling edge measures the high time
// (wrapping 32-bit difference, saturated to 65535 us), replaces the oldest
// of the channel's WINDOW_LEN samples and returns the channel and the window
// sum divided by WINDOW_LEN. Each result passes through stage 1, stage 2 and
// the output stage. The sample store is one RAM of CHANNEL_COUNT *
// WINDOW_LEN entries, read in stage 0 and written back from stage 1; events
// back to back on the same entry are forwarded. A stall on the result side
// freezes the three-stage pipeline and stalls the input in the same cycle.
// Per-entry valid bits make every sample read as zero after reset; there is
// no clearing pass, so the block takes events right out of reset.
module rc_pulse_width_averager_top #(
    parameter int unsigned WINDOW_LEN    = 10,
    parameter int unsigned CHANNEL_COUNT = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rpwa_pkg::CHANNEL_W-1:0] channel_index,
    input  wire logic                          pin_level,
    input  wire logic [rpwa_pkg::TIME_W-1:0]   timestamp_us,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rpwa_pkg::CHANNEL_W-1:0] out_channel,
    output logic      [rpwa_pkg::SAMPLE_W-1:0] average_width
);

    localparam int unsigned ENTRIES = CHANNEL_COUNT * WINDOW_LEN;
    localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int unsigned POS_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

    // Reciprocal for the divide by WINDOW_LEN; exact for every SUM_W-bit sum
    localparam int unsigned DIV_SHIFT = rpwa_pkg::SUM_W + 5;
    localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(RECIP_VAL);
    localparam int unsigned PROD_W = rpwa_pkg::SUM_W + RECIP_W;

    // Per-channel state
    logic [rpwa_pkg::TIME_W-1:0]   start_reg [CHANNEL_COUNT];
    logic [POS_W-1:0]              pos_reg   [CHANNEL_COUNT];
    logic [rpwa_pkg::SUM_W-1:0]    sum_reg   [CHANNEL_COUNT];
    logic [ENTRIES-1:0]            vld_reg;

    // Stage 1: sample read in flight
    logic                          s1_valid_reg;
    logic [CH_W-1:0]               s1_ch_reg;
    logic [rpwa_pkg::CHANNEL_W-1:0] s1_chan_reg;
    logic [ADDR_W-1:0]             s1_addr_reg;
    logic [rpwa_pkg::SAMPLE_W-1:0] s1_width_reg;
    logic                          s1_fwd_reg;
    logic [rpwa_pkg::SAMPLE_W-1:0] s1_fwd_data_reg;
    logic                          s1_old_vld_reg;

    // Stage 2: updated sum
    logic                          s2_valid_reg;
    logic [rpwa_pkg::CHANNEL_W-1:0] s2_chan_reg;
    logic [rpwa_pkg::SUM_W-1:0]    s2_sum_reg;

    // Output stage
    logic                          out_valid_reg;
    logic [rpwa_pkg::CHANNEL_W-1:0] out_channel_reg;
    logic [rpwa_pkg::SAMPLE_W-1:0] average_reg;

    logic                          advance;
    logic                          accept;
    logic                          ch_ok;
    logic                          is_fall;
    logic [CH_W-1:0]               ch_sel;
    logic [POS_W-1:0]              pos_cur;
    logic [POS_W-1:0]              pos_next;
    logic [rpwa_pkg::TIME_W-1:0]   diff;
    logic [rpwa_pkg::SAMPLE_W-1:0] width_sat;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          fwd_next;
    logic [rpwa_pkg::SAMPLE_W-1:0] ram_rd_data;
    logic [rpwa_pkg::SAMPLE_W-1:0] old_sample;
    logic [rpwa_pkg::SUM_W-1:0]    sum_next;
    logic                          s1_write;
    logic [PROD_W-1:0]             product;

    // Pipeline moves unless a finished word is held at the output
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // Stage 0: decode, width, ring address
    assign ch_ok     = (32'(channel_index) < 32'(CHANNEL_COUNT));
    assign is_fall   = (pin_level == rpwa_pkg::LEVEL_LOW);
    assign ch_sel    = CH_W'(channel_index);
    assign pos_cur   = pos_reg[ch_sel];
    assign pos_next  = (pos_cur >= POS_LAST) ? '0 : POS_W'(pos_cur + 1'b1);
    assign diff      = timestamp_us - start_reg[ch_sel];
    assign width_sat = (|diff[rpwa_pkg::TIME_W-1:rpwa_pkg::SAMPLE_W]) ?
                       rpwa_pkg::WIDTH_MAX : diff[rpwa_pkg::SAMPLE_W-1:0];
    assign rd_addr   = ADDR_W'(32'(ch_sel) * 32'(WINDOW_LEN) + 32'(pos_cur));

    // Entry being written back by stage 1 this cycle is forwarded
    assign s1_write = s1_valid_reg && advance;
    assign fwd_next = s1_write && (s1_addr_reg == rd_addr);

    rpwa_ram #(
        .WIDTH (rpwa_pkg::SAMPLE_W),
        .DEPTH (ENTRIES),
        .ADDR_W(ADDR_W)
    ) u_samples (
        .clk    (clk),
        .wr_en  (s1_write),
        .wr_addr(s1_addr_reg),
        .wr_data(s1_width_reg),
        .rd_en  (advance),
        .rd_addr(rd_addr),
        .rd_data(ram_rd_data)
    );

    // Stage 1: oldest sample out, new one in
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            old_sample = s1_fwd_data_reg;
        end
        else if (s1_old_vld_reg)
        begin
            old_sample = ram_rd_data;
        end
        else
        begin
            old_sample = '0;
        end
    end

    assign sum_next = sum_reg[s1_ch_reg]
                    - rpwa_pkg::SUM_W'(old_sample)
                    + rpwa_pkg::SUM_W'(s1_width_reg);

    // Divide by WINDOW_LEN through the reciprocal
    assign product = PROD_W'(s2_sum_reg) * PROD_W'(DIV_RECIP);

    // Control and per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                start_reg[i] <= '0;
                pos_reg[i]   <= '0;
                sum_reg[i]   <= '0;
            end
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && ch_ok)
            begin
                if (is_fall)
                begin
                    pos_reg[ch_sel] <= pos_next;
                end
                else
                begin
                    start_reg[ch_sel] <= timestamp_us;
                end
            end
            if (s1_write)
            begin
                sum_reg[s1_ch_reg]   <= sum_next;
                vld_reg[s1_addr_reg] <= 1'b1;
            end
            if (advance)
            begin
                s1_valid_reg  <= accept && ch_ok && is_fall;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ch_reg       <= ch_sel;
            s1_chan_reg     <= channel_index;
            s1_addr_reg     <= rd_addr;
            s1_width_reg    <= width_sat;
            s1_fwd_reg      <= fwd_next;
            s1_fwd_data_reg <= s1_width_reg;
            s1_old_vld_reg  <= vld_reg[rd_addr];
            s2_chan_reg     <= s1_chan_reg;
            s2_sum_reg      <= sum_next;
            out_channel_reg <= s2_chan_reg;
            average_reg     <= product[DIV_SHIFT +: rpwa_pkg::SAMPLE_W];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign average_width = average_reg;

`ifndef SYNTHESIS
    // Rising edges and unknown channels never reach the sample pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (!is_fall || !ch_ok)) |=> !s1_valid_reg)
        else $error("non-falling event entered the pipeline");

    // A falling edge carries its saturated width into stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ch_ok && is_fall) |=> (s1_valid_reg && s1_width_reg == $past(width_sat)))
        else $error("falling edge lost or width corrupted");

    // Ring position of a live channel stays inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_ok |-> (32'(pos_cur) < 32'(WINDOW_LEN)))
        else $error("ring position out of range");

    // A frozen pipeline keeps its stage-1 entry for the write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && s1_valid_reg) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stage 1 moved while stalled");

    // Forwarding only happens against a real write to the same entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fwd_next) |-> (s1_valid_reg && s1_addr_reg == rd_addr))
        else $error("bad forward");
`endif

endmodule

`default_nettype wire

@@ tb/rpwa_average_checker.sv @@
`timescale 1ns / 100ps
// Checker for the RC pulse-width averager: watches both handshakes, predicts
// each channel's moving average and compares every result word in order.
// Depends on rpwa_pkg.

module rpwa_average_checker #(
    parameter int unsigned WINDOW_LEN    = 10,
    parameter int unsigned CHANNEL_COUNT = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [rpwa_pkg::CHANNEL_W-1:0]    channel_index,
    input  logic                              pin_level,
    input  logic [rpwa_pkg::TIME_W-1:0]       timestamp_us,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [rpwa_pkg::CHANNEL_W-1:0]    out_channel,
    input  logic [rpwa_pkg::SAMPLE_W-1:0]     average_width,
    output int                                mismatch_count,
    output int                                pending_count
);

    typedef struct packed {
        logic [rpwa_pkg::CHANNEL_W-1:0] channel;
        logic [rpwa_pkg::SAMPLE_W-1:0]  width;
    } average_word_t;

    // Shadow state of the block
    logic [rpwa_pkg::TIME_W-1:0]   rise_time  [CHANNEL_COUNT];
    logic [rpwa_pkg::SAMPLE_W-1:0] pulse_ring [CHANNEL_COUNT][WINDOW_LEN];
    int unsigned                   ring_slot  [CHANNEL_COUNT];
    logic [rpwa_pkg::SUM_W-1:0]    ring_sum   [CHANNEL_COUNT];

    average_word_t expected_averages[$];

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            rise_time[c] = '0;
            ring_slot[c] = 0;
            ring_sum[c]  = '0;
            for (int s = 0; s < WINDOW_LEN; s++)
                pulse_ring[c][s] = '0;
        end
    end

    // Rising edge stores the start; falling edge measures, updates the ring
    // and queues the channel's new average
    task automatic track_edge(input logic [rpwa_pkg::CHANNEL_W-1:0] ch,
                              input logic level,
                              input logic [rpwa_pkg::TIME_W-1:0] stamp);
        logic [rpwa_pkg::TIME_W-1:0]   span;
        logic [rpwa_pkg::SAMPLE_W-1:0] width;
        int unsigned                   slot;
        average_word_t                 word;
        if (ch >= CHANNEL_COUNT)
            return;
        if (level == rpwa_pkg::LEVEL_HIGH)
        begin
            rise_time[ch] = stamp;
            return;
        end
        span  = stamp - rise_time[ch];
        width = (span > rpwa_pkg::TIME_W'(rpwa_pkg::WIDTH_MAX)) ?
                rpwa_pkg::WIDTH_MAX : span[rpwa_pkg::SAMPLE_W-1:0];
        slot  = ring_slot[ch];
        if (slot >= WINDOW_LEN)
            slot = 0;
        ring_sum[ch] = ring_sum[ch] - pulse_ring[ch][slot] + width;
        pulse_ring[ch][slot] = width;
        slot = slot + 1;
        if (slot >= WINDOW_LEN)
            slot = 0;
        ring_slot[ch] = slot;
        word.channel = ch;
        word.width   = rpwa_pkg::SAMPLE_W'(ring_sum[ch] / WINDOW_LEN);
        expected_averages.push_back(word);
    endtask

    // Compare first: a word accepted now can never belong to this edge's input
    always @(posedge clk)
    begin
        average_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_averages.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: extra result word: expected none, got channel %0d avg %0d",
                             $time, out_channel, average_width);
                end
                else
                begin
                    want = expected_averages.pop_front();
                    if (out_channel !== want.channel)
                    begin
                        mismatch_count++;
                        $display("%0t: out_channel: expected %0d, got %0d",
                                 $time, want.channel, out_channel);
                    end
                    if (average_width !== want.width)
                    begin
                        mismatch_count++;
                        $display("%0t: average_width (ch %0d): expected %0d, got %0d",
                                 $time, want.channel, want.width, average_width);
                    end
                end
            end
            if (in_valid && !in_stall)
                track_edge(channel_index, pin_level, timestamp_us);
            pending_count = expected_averages.size();
        end
    end

endmodule

@@ tb/rc_pulse_width_averager_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top for rc_pulse_width_averager_top: drives pin-change words,
// paces both sides and gives the verdict. Depends on rpwa_pkg, the block
// and rpwa_average_checker.

module rc_pulse_width_averager_top_test;

    localparam int unsigned WINDOW_LEN    = 10;
    localparam int unsigned CHANNEL_COUNT = 4;
    localparam int          EDGE_TARGET   = 1700;
    localparam int          QUIET_TAIL    = 200;
    localparam int          CYCLE_LIMIT   = 500000;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [rpwa_pkg::CHANNEL_W-1:0]  channel_index;
    logic                            pin_level;
    logic [rpwa_pkg::TIME_W-1:0]     timestamp_us;
    logic                            out_valid;
    logic                            out_stall;
    logic [rpwa_pkg::CHANNEL_W-1:0]  out_channel;
    logic [rpwa_pkg::SAMPLE_W-1:0]   average_width;

    int  mismatch_count;
    int  pending_count;
    int  edges_sent;
    int  cycle_count;
    bit  pacing_on;

    rc_pulse_width_averager_top #(
        .WINDOW_LEN    (WINDOW_LEN),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel_index (channel_index),
        .pin_level     (pin_level),
        .timestamp_us  (timestamp_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_channel   (out_channel),
        .average_width (average_width)
    );

    rpwa_average_checker #(
        .WINDOW_LEN    (WINDOW_LEN),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) averages_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .channel_index  (channel_index),
        .pin_level      (pin_level),
        .timestamp_us   (timestamp_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_channel    (out_channel),
        .average_width  (average_width),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result-side stall bursts, started at random while pacing is on
    initial
    begin
        int unsigned hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
            else if (pacing_on && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 11);
                out_stall <= 1'b1;
            end
        end
    end

    // One pin-change word, with an optional gap ahead of it
    task automatic send_edge(input logic [rpwa_pkg::CHANNEL_W-1:0] ch, input logic level,
                             input logic [rpwa_pkg::TIME_W-1:0] stamp);
        int unsigned gap;
        if (pacing_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        channel_index <= ch;
        pin_level     <= level;
        timestamp_us  <= stamp;
        do
            @(posedge clk);
        while (in_stall);
        edges_sent++;
    endtask

    initial
    begin
        logic [rpwa_pkg::TIME_W-1:0]    clock_us;
        logic [rpwa_pkg::TIME_W-1:0]    width;
        logic [rpwa_pkg::CHANNEL_W-1:0] ch;
        logic [rpwa_pkg::CHANNEL_W-1:0] other;
        int                             pick;
        int                             next_switch;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        channel_index <= '0;
        pin_level     <= rpwa_pkg::LEVEL_LOW;
        timestamp_us  <= '0;
        pacing_on     = 1'b0;
        edges_sent    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Falling edges with no rising edge measure from a zero start
        send_edge(2'd0, rpwa_pkg::LEVEL_LOW, 32'd0);
        send_edge(2'd1, rpwa_pkg::LEVEL_LOW, 32'd1234);
        send_edge(2'd1, rpwa_pkg::LEVEL_LOW, 32'hFFFF_FFFF);
        // Timestamp wraps inside the pulse
        send_edge(2'd2, rpwa_pkg::LEVEL_HIGH, 32'hFFFF_FFF0);
        send_edge(2'd2, rpwa_pkg::LEVEL_LOW, 32'h0000_0010);
        // Exactly the largest width, then one past it saturates
        send_edge(2'd3, rpwa_pkg::LEVEL_HIGH, 32'h0000_1000);
        send_edge(2'd3, rpwa_pkg::LEVEL_LOW, 32'h0000_1000 + 32'd65535);
        send_edge(2'd3, rpwa_pkg::LEVEL_HIGH, 32'd5);
        send_edge(2'd3, rpwa_pkg::LEVEL_LOW, 32'd5 + 32'd65536);
        // Repeated rising edges: the latest start wins; two falls share it
        send_edge(2'd0, rpwa_pkg::LEVEL_HIGH, 32'd1000);
        send_edge(2'd0, rpwa_pkg::LEVEL_HIGH, 32'd2000);
        send_edge(2'd0, rpwa_pkg::LEVEL_LOW, 32'd2500);
        send_edge(2'd0, rpwa_pkg::LEVEL_LOW, 32'd2600);
        // Zero-length pulse
        send_edge(2'd1, rpwa_pkg::LEVEL_HIGH, 32'd0);
        send_edge(2'd1, rpwa_pkg::LEVEL_LOW, 32'd0);
        // Fill and wrap one ring with saturated widths, back to back
        send_edge(2'd2, rpwa_pkg::LEVEL_HIGH, 32'd0);
        repeat (WINDOW_LEN + 1)
            send_edge(2'd2, rpwa_pkg::LEVEL_LOW, 32'hFFFF_FFFF);

        // Random part: mostly well-formed pulses, some noise
        clock_us    = $urandom();
        next_switch = edges_sent;
        while (edges_sent < EDGE_TARGET)
        begin
            if (edges_sent >= EDGE_TARGET - QUIET_TAIL)
                pacing_on = 1'b0;
            else if (edges_sent >= next_switch)
            begin
                pacing_on   = ($urandom_range(0, 3) != 0);
                next_switch = edges_sent + $urandom_range(60, 200);
            end
            pick = $urandom_range(0, 99);
            ch   = rpwa_pkg::CHANNEL_W'($urandom_range(0, CHANNEL_COUNT - 1));
            if (pick < 70)
            begin
                // Rise/fall pair, width mostly in the servo range
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: width = $urandom_range(900, 2100);
                    6:                width = $urandom_range(0, 20);
                    7:                width = $urandom_range(0, 65535);
                    8:                width = 65535 + $urandom_range(0, 2);
                    default:          width = $urandom();
                endcase
                send_edge(ch, rpwa_pkg::LEVEL_HIGH, clock_us);
                send_edge(ch, rpwa_pkg::LEVEL_LOW, clock_us + width);
                clock_us = clock_us + width + $urandom_range(0, 20000);
            end
            else if (pick < 80)
            begin
                // Run of falls on one channel without a new start
                repeat ($urandom_range(3, 12))
                begin
                    clock_us = clock_us + $urandom_range(0, 3000);
                    send_edge(ch, rpwa_pkg::LEVEL_LOW, clock_us);
                end
            end
            else if (pick < 90)
            begin
                // Two channels with overlapping pulses
                other = rpwa_pkg::CHANNEL_W'($urandom_range(0, CHANNEL_COUNT - 1));
                send_edge(ch, rpwa_pkg::LEVEL_HIGH, clock_us);
                send_edge(other, rpwa_pkg::LEVEL_HIGH, clock_us + $urandom_range(0, 400));
                send_edge(ch, rpwa_pkg::LEVEL_LOW, clock_us + $urandom_range(800, 2200));
                send_edge(other, rpwa_pkg::LEVEL_LOW, clock_us + $urandom_range(2200, 3000));
                clock_us = clock_us + 5000;
            end
            else
            begin
                // Noise: any channel, level and time
                send_edge(ch, 1'($urandom_range(0, 1)), $urandom());
            end
        end
        in_valid <= 1'b0;

        // Drain, then allow the pipeline depth to pass
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rpwa_pkg.sv
rtl/core/rpwa_ram.sv
rtl/core/rc_pulse_width_averager_top.sv
tb/rpwa_average_checker.sv
tb/rc_pulse_width_averager_top_test.sv
